### src/jetp_pkg.sv
// ----------------------------------------------------------------------------
// jetp_pkg
// Shared types, constants and helpers for the Julia escape-time pixel core.
// ----------------------------------------------------------------------------
package jetp_pkg;

    // image geometry used by the coordinate mapping
    localparam int IMAGE_WIDTH  = 800;
    localparam int IMAGE_HEIGHT = 800;

    // fixed-point format: signed Q4.28
    localparam int Q_W       = 32;
    localparam int FRAC_BITS = 28;

    // field widths
    localparam int PIX_W   = 10;
    localparam int ITER_W  = 16;
    localparam int CNT_W   = 17;
    localparam int INT_W   = 8;
    localparam int IDX_W   = 2;

    // stream payload widths, rounded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // intensity divider: dividend holds 255*count, divisor holds the limit
    localparam int DIVD_W = CNT_W + INT_W;
    localparam int DVS_W  = ITER_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    // coordinate mapping: (p << 30) / dim as p * ceil(2^52 / dim) >> 22,
    // exact floor since p * (M * dim - 2^52) < 2^22 for any 10-bit pixel
    localparam int MAPQ_W  = PIX_W + 30;
    localparam int MAP_SH  = 22;
    localparam int MAP_M_W = 52;
    localparam int MAP_P_W = PIX_W + MAP_M_W;
    localparam logic [MAP_M_W-1:0] MAP_MX = MAP_M_W'(((64'd1 << (30 + MAP_SH))
        + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
    localparam logic [MAP_M_W-1:0] MAP_MY = MAP_M_W'(((64'd1 << (30 + MAP_SH))
        + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));

    // saturation input width, wide enough for every intermediate term
    localparam int SAT_W = 41;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic [IDX_W-1:0]      t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_C_REAL   = 2'd0;
    localparam t_cfg_idx CFG_C_IMAG   = 2'd1;
    localparam t_cfg_idx CFG_MAX_ITER = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;
    localparam logic [CNT_W-1:0]  CNT_START    = 17'd3;

    // clamp to the Q4.28 range
    function automatic t_q sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(signed'(33'sh0_7FFF_FFFF));
        lo = -hi - SAT_W'(1);
        if (v > hi) begin
            return t_q'(hi);
        end else if (v < lo) begin
            return t_q'(lo);
        end
        return t_q'(v);
    endfunction

endpackage

### src/julia_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core
// Escape-time evaluator for one pixel of a Julia set in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// One pixel item is taken at a time. The core maps the pixel to a start point
// by reciprocal multiplication, one coordinate at a time, then runs
// z = z*z + c on a single shared 32x32 multiplier, each iteration taking
// three products and one update; the escape and limit test is made with the
// third product. When the count ends below max_iterations, a restoring
// division forms the intensity. The input is ready again from the cycle the
// result is loaded. The result sits in an output register, so the next pixel
// is taken while a result still waits. Configuration writes are always accepted.
module julia_escape_time_pixel_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  jetp_pkg::t_cfg_idx            i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // pixel input: [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [jetp_pkg::S_DATA_W-1:0] i_s_tdata,
    // result: [7:0] intensity, [24:8] final_count, [31:25] zero
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [jetp_pkg::M_DATA_W-1:0] o_m_tdata
);
    import jetp_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAPX   = 4'd1;
    localparam logic [3:0] ST_MAPY   = 4'd2;
    localparam logic [3:0] ST_MUL_RR = 4'd3;
    localparam logic [3:0] ST_MUL_II = 4'd4;
    localparam logic [3:0] ST_MUL_RI = 4'd5;
    localparam logic [3:0] ST_UPDATE = 4'd6;
    localparam logic [3:0] ST_DIVI   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIVD_W - 1);
    localparam logic signed [SAT_W-1:0] TWO_Q = SAT_W'(2) <<< FRAC_BITS;

    // control
    logic [3:0]        r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_q                r_c_real, n_c_real;
    t_q                r_c_imag, n_c_imag;
    logic [ITER_W-1:0] r_max_iter, n_max_iter;
    logic [DCNT_W-1:0] r_div_cnt, n_div_cnt;

    // datapath
    logic [PIX_W-1:0]  r_px, n_px;
    logic [PIX_W-1:0]  r_py, n_py;
    t_q                r_re, n_re;
    t_q                r_im, n_im;
    logic [62:0]       r_rr, n_rr;
    logic [62:0]       r_ii, n_ii;
    logic signed [63:0] r_ri, n_ri;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [INT_W-1:0]  r_int, n_int;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;
    logic [INT_W-1:0]  r_out_int, n_out_int;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    // shared multiplier
    t_q                 mul_a, mul_b;
    logic signed [63:0] mul_p;

    // coordinate mapping
    logic [MAP_P_W-1:0] map_px_p, map_py_p;
    logic [MAPQ_W-1:0]  map_quo;
    t_q                 map_q;

    // divider step
    logic [DVS_W:0]    rem_sh;
    logic              div_ge;
    logic [DVS_W-1:0]  rem_nx;
    logic [DIVD_W-1:0] quo_nx;

    // iteration terms
    logic [63:0]        esc_sum;
    logic               esc_hit, lim_hit, below_lim;
    t_q                 t_rr, t_ii, t_ri;
    logic signed [SAT_W-1:0] sum_re, sum_im;
    logic [DIVD_W-1:0]  scaled_cnt;

    logic in_acc, out_acc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_cnt, r_out_int};

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = r_out_valid && i_m_tready;

    always_comb begin
        unique case (r_state)
            ST_MUL_RR: begin
                mul_a = r_re;
                mul_b = r_re;
            end
            ST_MUL_II: begin
                mul_a = r_im;
                mul_b = r_im;
            end
            default: begin
                mul_a = r_re;
                mul_b = r_im;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // (p << 30) / dim by multiplication with a constant reciprocal
    assign map_px_p = MAP_P_W'(r_px) * MAP_P_W'(MAP_MX);
    assign map_py_p = MAP_P_W'(r_py) * MAP_P_W'(MAP_MY);
    assign map_quo  = (r_state == ST_MAPY) ? map_py_p[MAP_P_W-1:MAP_SH]
                                           : map_px_p[MAP_P_W-1:MAP_SH];
    assign map_q    = sat_q($signed({1'b0, map_quo}) - TWO_Q);

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = div_ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
    assign quo_nx = {r_quo[DIVD_W-2:0], div_ge};

    // escape test at Q8.56 against 4.0
    assign esc_sum   = {1'b0, r_rr} + {1'b0, r_ii};
    assign esc_hit   = (esc_sum[63:2*FRAC_BITS+2] != '0);
    assign lim_hit   = r_count > {1'b0, r_max_iter};
    assign below_lim = r_count < {1'b0, r_max_iter};

    assign t_rr = sat_q($signed({6'd0, r_rr[62:FRAC_BITS]}));
    assign t_ii = sat_q($signed({6'd0, r_ii[62:FRAC_BITS]}));
    // arithmetic shift is the floor of 2*re*im
    assign t_ri = sat_q({{4{r_ri[63]}}, r_ri[63:FRAC_BITS-1]});
    assign sum_re = SAT_W'(t_rr) - SAT_W'(t_ii) + SAT_W'(r_c_real);
    assign sum_im = SAT_W'(t_ri) + SAT_W'(r_c_imag);

    assign scaled_cnt = {r_count, 8'd0} - DIVD_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_c_real    = r_c_real;
        n_c_imag    = r_c_imag;
        n_max_iter  = r_max_iter;
        n_div_cnt   = r_div_cnt;
        n_px        = r_px;
        n_py        = r_py;
        n_re        = r_re;
        n_im        = r_im;
        n_rr        = r_rr;
        n_ii        = r_ii;
        n_ri        = r_ri;
        n_count     = r_count;
        n_int       = r_int;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_out_int   = r_out_int;
        n_out_cnt   = r_out_cnt;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_C_REAL:   n_c_real   = t_q'(i_cfg_data);
                CFG_C_IMAG:   n_c_imag   = t_q'(i_cfg_data);
                CFG_MAX_ITER: n_max_iter = i_cfg_data[ITER_W-1:0];
                default:      ;
            endcase
        end

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        if (r_state == ST_DIVI) begin
            n_quo     = quo_nx;
            n_rem     = rem_nx;
            n_div_cnt = r_div_cnt + DCNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_px    = i_s_tdata[PIX_W-1:0];
                    n_py    = i_s_tdata[2*PIX_W-1:PIX_W];
                    n_count = CNT_START;
                    n_state = ST_MAPX;
                end
            end
            ST_MAPX: begin
                n_re    = map_q;
                n_state = ST_MAPY;
            end
            ST_MAPY: begin
                n_im    = map_q;
                n_state = ST_MUL_RR;
            end
            ST_MUL_RR: begin
                n_rr    = mul_p[62:0];
                n_state = ST_MUL_II;
            end
            ST_MUL_II: begin
                n_ii    = mul_p[62:0];
                n_state = ST_MUL_RI;
            end
            ST_MUL_RI: begin
                n_ri = mul_p;
                if (esc_hit || lim_hit) begin
                    if (below_lim) begin
                        n_quo     = scaled_cnt;
                        n_rem     = '0;
                        n_dvs     = r_max_iter;
                        n_div_cnt = '0;
                        n_state   = ST_DIVI;
                    end else begin
                        n_int   = '0;
                        n_state = ST_OUT;
                    end
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_re    = sat_q(sum_re);
                n_im    = sat_q(sum_im);
                n_count = r_count + CNT_W'(1);
                n_state = ST_MUL_RR;
            end
            ST_DIVI: begin
                if (r_div_cnt == DIV_LAST) begin
                    n_int   = quo_nx[INT_W-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_int   = r_int;
                    n_out_cnt   = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_c_real    <= '0;
            r_c_imag    <= '0;
            r_max_iter  <= MAX_ITER_RST;
            r_div_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_c_real    <= n_c_real;
            r_c_imag    <= n_c_imag;
            r_max_iter  <= n_max_iter;
            r_div_cnt   <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_py      <= n_py;
        r_re      <= n_re;
        r_im      <= n_im;
        r_rr      <= n_rr;
        r_ii      <= n_ii;
        r_ri      <= n_ri;
        r_count   <= n_count;
        r_int     <= n_int;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_out_int <= n_out_int;
        r_out_cnt <= n_out_cnt;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_tready)
        else $error("input ready right after an accepted item");

    a_count_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_cnt >= CNT_START))
        else $error("final count below start value");

    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVI) |-> (r_div_cnt <= DIV_LAST))
        else $error("divider step counter out of range");

    a_result_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_out_valid || i_m_tready)) |=> o_m_tvalid)
        else $error("result not presented after finishing an item");
`endif

endmodule

### test/julia_escape_time_pixel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core_tb
// Self-checking bench for the Julia escape-time pixel core. Pixel items are
// sent on the input stream and each result is compared against an in-bench
// fixed-point model of the escape loop. The run covers directed corners, the
// configuration extremes, output back-pressure and randomized scenes.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core_tb;
    import jetp_pkg::*;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;
    localparam longint Q_HI = 64'sh7FFF_FFFF;
    localparam longint Q_LO = -Q_HI - 1;
    localparam longint unsigned ESC_R2 = 64'd4 << (2 * FRAC_BITS);
    localparam int RED_FULL = 255;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic [CNT_W-1:0] final_count;
    } t_shade;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index = CFG_C_REAL;
    logic [31:0]         i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    // shadow copy of the core's registers
    longint cr_q       = 0;
    longint ci_q       = 0;
    int     iter_limit = MAX_ITER_RST;

    t_shade expected_shades[$];
    int     err_cnt     = 0;
    bit     idle_en     = 1'b1;
    int     hold_cycles = 0;

    julia_escape_time_pixel_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(200_000_000);
        $display("julia_escape_time_pixel_core_tb NOT OK");
        $finish;
    end

    // ---------------- escape-time model ----------------

    function automatic longint clamp_q(longint v);
        if (v > Q_HI) begin
            return Q_HI;
        end else if (v < Q_LO) begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic longint start_coord(logic [PIX_W-1:0] p, int dim);
        longint q;
        q = p;
        q = (q <<< 30) / dim;
        return clamp_q(q - (longint'(2) <<< FRAC_BITS));
    endfunction

    function automatic t_shade escape_shade(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint          re;
        longint          im;
        longint          t_rr;
        longint          t_ii;
        longint          t_ri;
        longint          nre;
        longint unsigned rr;
        longint unsigned ii;
        int              count;
        t_shade          s;
        re    = start_coord(px, IMAGE_WIDTH);
        im    = start_coord(py, IMAGE_HEIGHT);
        count = CNT_START;
        forever begin
            rr = re * re;
            ii = im * im;
            // escape compare is exact, at full product precision
            if (rr + ii >= ESC_R2 || count > iter_limit) break;
            t_rr  = clamp_q(longint'(rr >> FRAC_BITS));
            t_ii  = clamp_q(longint'(ii >> FRAC_BITS));
            t_ri  = clamp_q((re * im) >>> (FRAC_BITS - 1));
            nre   = clamp_q(t_rr - t_ii + cr_q);
            im    = clamp_q(t_ri + ci_q);
            re    = nre;
            count = count + 1;
        end
        s.final_count = CNT_W'(count);
        s.intensity   = (count < iter_limit) ? INT_W'((RED_FULL * count) / iter_limit) : '0;
        return s;
    endfunction

    // ---------------- drivers ----------------

    // called at a clock edge; leaves tvalid high after the handshake
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = idle_en ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W - 2 * PIX_W){1'b0}}, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        expected_shades.push_back(escape_shade(px, py));
    endtask

    task automatic send_random_pixel();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        // now and then a coordinate past the image edge
        px = PIX_W'(($urandom_range(0, 15) == 0) ? $urandom_range(IMAGE_WIDTH, 1023)
                                                 : $urandom_range(0, IMAGE_WIDTH - 1));
        py = PIX_W'(($urandom_range(0, 15) == 0) ? $urandom_range(IMAGE_HEIGHT, 1023)
                                                 : $urandom_range(0, IMAGE_HEIGHT - 1));
        send_pixel(px, py);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_shades.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_C_REAL:   cr_q = longint'(signed'(data));
            CFG_C_IMAG:   ci_q = longint'(signed'(data));
            CFG_MAX_ITER: iter_limit = data[ITER_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_c();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
        endcase
    endfunction

    // ---------------- result side ----------------

    initial begin : result_sink
        int stall;
        forever begin
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = idle_en ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_shade want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_shades.size() == 0) begin
                $error("unexpected result, tdata %h", o_m_tdata);
                err_cnt++;
            end else begin
                want = expected_shades.pop_front();
                if (o_m_tdata[INT_W-1:0] !== want.intensity) begin
                    $error("intensity: expected %0d, got %0d",
                           want.intensity, o_m_tdata[INT_W-1:0]);
                    err_cnt++;
                end
                if (o_m_tdata[INT_W+CNT_W-1:INT_W] !== want.final_count) begin
                    $error("final_count: expected %0d, got %0d",
                           want.final_count, o_m_tdata[INT_W+CNT_W-1:INT_W]);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_pixel(0, 0);
        send_pixel(400, 400);   // z starts at 0, never escapes
        send_pixel(799, 799);
        send_pixel(0, 799);
        send_pixel(799, 0);
        send_pixel(1023, 1023); // past the image edge
        send_pixel(800, 0);
        send_pixel(600, 300);
        drain();
    endtask

    task automatic test_register_extremes();
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);   // must be ignored
        send_pixel(400, 400);
        drain();
        cfg_write(CFG_C_REAL, 32'h7FFF_FFFF);
        cfg_write(CFG_C_IMAG, 32'h8000_0000);
        cfg_write(CFG_MAX_ITER, 32'd4);
        send_pixel(400, 400);
        send_pixel(0, 0);
        drain();
        cfg_write(CFG_C_REAL, 32'h8000_0000);
        cfg_write(CFG_C_IMAG, 32'h7FFF_FFFF);
        send_pixel(400, 400);
        send_pixel(123, 456);
        drain();
        // roughly -0.8 + 0.156i
        cfg_write(CFG_C_REAL, 32'hF333_3333);
        cfg_write(CFG_C_IMAG, 32'h027F_62B7);
        cfg_write(CFG_MAX_ITER, 32'd60);
        send_pixel(350, 420);
        send_pixel(500, 380);
        drain();
    endtask

    task automatic test_longest_limit();
        cfg_write(CFG_C_REAL, 32'd0);
        cfg_write(CFG_C_IMAG, 32'd0);
        cfg_write(CFG_MAX_ITER, 32'hFFFF);
        send_pixel(0, 0);
        send_pixel(400, 400);   // runs the loop up to the largest iteration limit
        send_pixel(799, 799);
        drain();
        cfg_write(CFG_MAX_ITER, 32'd40);
    endtask

    task automatic test_output_backpressure();
        idle_en     = 1'b0;
        hold_cycles = 2000;
        repeat (8) send_random_pixel();
        drain();
        idle_en = 1'b1;
    endtask

    task automatic test_random_scenes(input int n_items);
        int sent;
        int batch;
        sent = 0;
        while (sent < n_items) begin
            cfg_write(CFG_C_REAL, pick_c());
            cfg_write(CFG_C_IMAG, pick_c());
            cfg_write(CFG_MAX_ITER, ($urandom_range(0, 7) == 0) ? $urandom_range(4, 300)
                                                                : $urandom_range(4, 64));
            idle_en = ($urandom_range(0, 3) != 0);
            batch   = $urandom_range(60, 160);
            repeat (batch) send_random_pixel();
            sent += batch;
            drain();
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_longest_limit();
        test_output_backpressure();
        test_random_scenes(N_RANDOM);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("julia_escape_time_pixel_core_tb OK");
        end else begin
            $display("julia_escape_time_pixel_core_tb NOT OK");
        end
        $finish;
    end

endmodule
